// ===== src/tga_pkg.sv =====
// Package with the shared types and constants of the TGA true-colour RLE decoder.
package tga_pkg;

	localparam int unsigned SKIP_W = 24;
	localparam int unsigned MAP_W = 22;
	localparam int unsigned AREA_W = 32;

	typedef enum logic [6:0] {
		PH_HEADER = 7'b0000001,
		PH_SKIP = 7'b0000010,
		PH_RAWIMG = 7'b0000100,
		PH_PKTHEAD = 7'b0001000,
		PH_PKTPIX = 7'b0010000,
		PH_DONE = 7'b0100000,
		PH_ERROR = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_RUN = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_TYPE = 2'd1;
	localparam logic [1:0] ERR_SIZE = 2'd2;
	localparam logic [1:0] ERR_TRUNC = 2'd3;

	localparam logic [4:0] HDR_ID_LEN = 5'd0;
	localparam logic [4:0] HDR_MAP_TYPE = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
	localparam logic [4:0] HDR_MAP_LEN_LO = 5'd5;
	localparam logic [4:0] HDR_MAP_LEN_HI = 5'd6;
	localparam logic [4:0] HDR_MAP_DEPTH = 5'd7;
	localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_DEPTH = 5'd16;
	localparam logic [4:0] HDR_LAST = 5'd17;

	localparam logic [7:0] TYPE_RAW = 8'd2;
	localparam logic [7:0] TYPE_RLE = 8'd10;
	localparam logic [7:0] DEPTH_24 = 8'd24;
	localparam logic [7:0] DEPTH_32 = 8'd32;

	typedef struct packed {
		kind_t kind;
		logic [1:0] error_code;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] run_length;
		logic last_run;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic has_alpha;
	} res_t;

endpackage

// ===== src/tga_core.sv =====
// Header parser, skip counter, packet tracker and pixel assembler of the decoder.
module tga_core
	import tga_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] data_byte,
	input logic end_of_file,
	output logic res_valid,
	output res_t res
);

	phase_t phase_q, phase_n;
	logic [4:0] hdr_idx_q, hdr_idx_n;
	logic [7:0] image_type_q, image_type_n;
	logic [15:0] width_q, width_n;
	logic [15:0] height_q, height_n;
	logic [7:0] depth_q, depth_n;
	logic [7:0] map_type_q, map_type_n;
	logic [15:0] map_len_q, map_len_n;
	logic [7:0] map_depth_q, map_depth_n;
	logic [SKIP_W-1:0] skip_q, skip_n;
	logic [23:0] gather_q, gather_n;
	logic [1:0] bip_q, bip_n;
	logic [7:0] pkt_left_q, pkt_left_n;
	logic pkt_run_q, pkt_run_n;
	logic [AREA_W-1:0] pix_left_q, pix_left_n;

	logic [MAP_W-1:0] map_bytes_q;
	logic [AREA_W-1:0] area_q;
	logic [8:0] depth_round;
	logic [5:0] entry_bytes;
	logic [SKIP_W-1:0] skip_sum;
	phase_t data_phase;
	logic four_bytes;
	logic last_byte;
	logic [7:0] cnt;
	logic [7:0] pkt_dec;
	logic fin;

	assign depth_round = {1'b0, map_depth_q} + 9'd7;
	assign entry_bytes = depth_round[8:3];
	assign skip_sum = SKIP_W'(skip_q[7:0]) + SKIP_W'(map_bytes_q);
	assign data_phase = (image_type_q == TYPE_RAW) ? PH_RAWIMG : PH_PKTHEAD;
	assign four_bytes = (depth_q == DEPTH_32);
	assign last_byte = (bip_q == (four_bytes ? 2'd3 : 2'd2));
	assign pkt_dec = pkt_left_q - 8'd1;

	always_ff @(posedge clk) begin
		map_bytes_q <= (map_type_q != 8'd0) ? MAP_W'(map_len_q) * MAP_W'(entry_bytes) : '0;
		area_q <= AREA_W'(width_q) * AREA_W'(height_q);
	end

	always_comb begin
		phase_n = phase_q;
		hdr_idx_n = hdr_idx_q;
		image_type_n = image_type_q;
		width_n = width_q;
		height_n = height_q;
		depth_n = depth_q;
		map_type_n = map_type_q;
		map_len_n = map_len_q;
		map_depth_n = map_depth_q;
		skip_n = skip_q;
		gather_n = gather_q;
		bip_n = bip_q;
		pkt_left_n = pkt_left_q;
		pkt_run_n = pkt_run_q;
		pix_left_n = pix_left_q;
		cnt = 8'd1;
		fin = 1'b0;
		res = '0;
		res_valid = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				unique case (hdr_idx_q)
					HDR_ID_LEN: skip_n = SKIP_W'(data_byte);
					HDR_MAP_TYPE: map_type_n = data_byte;
					HDR_IMG_TYPE: image_type_n = data_byte;
					HDR_MAP_LEN_LO: map_len_n[7:0] = data_byte;
					HDR_MAP_LEN_HI: map_len_n[15:8] = data_byte;
					HDR_MAP_DEPTH: map_depth_n = data_byte;
					HDR_WIDTH_LO: width_n[7:0] = data_byte;
					HDR_WIDTH_HI: width_n[15:8] = data_byte;
					HDR_HEIGHT_LO: height_n[7:0] = data_byte;
					HDR_HEIGHT_HI: height_n[15:8] = data_byte;
					HDR_DEPTH: depth_n = data_byte;
					default: ;
				endcase
				if (hdr_idx_q != HDR_LAST) begin
					hdr_idx_n = hdr_idx_q + 5'd1;
				end else begin
					hdr_idx_n = '0;
					res_valid = 1'b1;
					if (image_type_q != TYPE_RAW && image_type_q != TYPE_RLE) begin
						phase_n = PH_ERROR;
						fin = 1'b1;
						res.kind = KIND_ERROR;
						res.error_code = ERR_TYPE;
					end else if (width_q == 16'd0 || height_q == 16'd0 ||
							(depth_q != DEPTH_24 && depth_q != DEPTH_32)) begin
						phase_n = PH_ERROR;
						fin = 1'b1;
						res.kind = KIND_ERROR;
						res.error_code = ERR_SIZE;
					end else begin
						skip_n = skip_sum;
						pix_left_n = area_q;
						gather_n = '0;
						bip_n = '0;
						pkt_left_n = '0;
						pkt_run_n = 1'b0;
						phase_n = (skip_sum != '0) ? PH_SKIP : data_phase;
						res.kind = KIND_HEADER;
						res.image_width = width_q;
						res.image_height = height_q;
						res.has_alpha = four_bytes;
					end
				end
			end
			PH_SKIP: begin
				skip_n = skip_q - SKIP_W'(1);
				if (skip_n == '0) begin
					phase_n = data_phase;
				end
			end
			PH_RAWIMG, PH_PKTPIX: begin
				if (!last_byte) begin
					unique case (bip_q)
						2'd0: gather_n[7:0] = data_byte;
						2'd1: gather_n[15:8] = data_byte;
						2'd2: gather_n[23:16] = data_byte;
						default: ;
					endcase
					bip_n = bip_q + 2'd1;
				end else begin
					gather_n = '0;
					bip_n = '0;
					if (phase_q == PH_PKTPIX) begin
						if (pkt_run_q) begin
							cnt = pkt_left_q;
							if ({24'd0, pkt_left_q} > pix_left_q) begin
								cnt = pix_left_q[7:0];
							end
							pkt_left_n = '0;
							phase_n = PH_PKTHEAD;
						end else begin
							pkt_left_n = pkt_dec;
							if (pkt_dec == 8'd0) begin
								phase_n = PH_PKTHEAD;
							end
						end
					end
					pix_left_n = pix_left_q - AREA_W'(cnt);
					res_valid = 1'b1;
					res.kind = KIND_RUN;
					res.blue = gather_q[7:0];
					res.green = gather_q[15:8];
					res.red = four_bytes ? gather_q[23:16] : data_byte;
					res.alpha = four_bytes ? data_byte : 8'hFF;
					res.run_length = cnt;
					res.has_alpha = four_bytes;
					if (pix_left_n == '0) begin
						res.last_run = 1'b1;
						phase_n = PH_DONE;
						fin = 1'b1;
					end
				end
			end
			PH_PKTHEAD: begin
				pkt_run_n = data_byte[7];
				pkt_left_n = {1'b0, data_byte[6:0]} + 8'd1;
				phase_n = PH_PKTPIX;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
		if (end_of_file) begin
			phase_n = PH_HEADER;
			hdr_idx_n = '0;
			if (!fin) begin
				res_valid = 1'b1;
				res = '0;
				res.kind = KIND_ERROR;
				res.error_code = ERR_TRUNC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_idx_q <= '0;
			image_type_q <= '0;
			width_q <= '0;
			height_q <= '0;
			depth_q <= '0;
			map_type_q <= '0;
			map_len_q <= '0;
			map_depth_q <= '0;
			skip_q <= '0;
			gather_q <= '0;
			bip_q <= '0;
			pkt_left_q <= '0;
			pkt_run_q <= 1'b0;
			pix_left_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			hdr_idx_q <= hdr_idx_n;
			image_type_q <= image_type_n;
			width_q <= width_n;
			height_q <= height_n;
			depth_q <= depth_n;
			map_type_q <= map_type_n;
			map_len_q <= map_len_n;
			map_depth_q <= map_depth_n;
			skip_q <= skip_n;
			gather_q <= gather_n;
			bip_q <= bip_n;
			pkt_left_q <= pkt_left_n;
			pkt_run_q <= pkt_run_n;
			pix_left_q <= pix_left_n;
		end
	end

endmodule

// ===== src/tga_rle_image_decoder_top.sv =====
// Top level of the TGA true-colour RLE decoder: input register, core and result register.
// An accepted byte waits in the input register and is decoded when the core steps; its
// result, if any, goes to the result register, where the output side can take it.
// Throughput is one byte per clock while the output side takes results; the decoder
// state update between the input and result registers is the loop that sets it.
// Asynchronous active-low reset returns the parser to the start of a file header.
module tga_rle_image_decoder_top
	import tga_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // data_byte
	input logic s_tlast, // end_of_file
	output logic m_tvalid,
	input logic m_tready,
	// error_code[1:0], red[9:2], green[17:10], blue[25:18], alpha[33:26],
	// run_length[41:34], image_width[57:42], image_height[73:58], has_alpha[74], zero[79:75]
	output logic [79:0] m_tdata,
	output logic m_tlast, // last_run
	output logic [1:0] m_tuser // result_kind
);

	logic in_valid_s1;
	logic [7:0] data_s1;
	logic eof_s1;
	logic out_valid_s2;
	res_t res_s2;
	logic step;
	logic core_valid;
	res_t core_res;

	assign step = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (step) begin
				out_valid_s2 <= core_valid;
			end else if (m_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			eof_s1 <= s_tlast;
		end
		if (step && core_valid) begin
			res_s2 <= core_res;
		end
	end

	tga_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.data_byte(data_s1),
		.end_of_file(eof_s1),
		.res_valid(core_valid),
		.res(core_res)
	);

	assign m_tvalid = out_valid_s2;
	assign m_tuser = res_s2.kind;
	assign m_tlast = res_s2.last_run;
	assign m_tdata = {5'd0, res_s2.has_alpha, res_s2.image_height, res_s2.image_width,
		res_s2.run_length, res_s2.alpha, res_s2.blue, res_s2.green, res_s2.red,
		res_s2.error_code};

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("Input stalled while the result register is empty.");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_RUN) |-> (m_tdata[41:34] != 8'd0))
		else $error("Pixel run with zero length.");

	a_header_size: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_HEADER) |->
		(m_tdata[57:42] != 16'd0 && m_tdata[73:58] != 16'd0))
		else $error("Header result with zero image size.");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == KIND_ERROR) == (m_tdata[1:0] != ERR_NONE)))
		else $error("Error code does not match result kind.");

endmodule

// ===== verif/tb_tga_rle_image_decoder_top.sv =====
// Self-checking testbench for the TGA true-colour RLE decoder top level.
`timescale 1ns / 1ps

module tb_tga_rle_image_decoder_top;
	import tga_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;

	typedef struct {
		logic [7:0] img_type;
		logic [7:0] depth;
		logic [15:0] width;
		logic [15:0] height;
		logic [7:0] id_len;
		logic [7:0] map_type;
		logic [15:0] map_len;
		logic [7:0] map_depth;
		int min_pkt;
		int max_pkt;
		int run_pct;
		int tail;
		int cut;
		logic [1:0] pin;
	} tga_file_t;

	logic clk;
	logic arst_n;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic m_tlast;
	logic [1:0] m_tuser;

	logic [1:0] item_pin = ERR_NONE;
	int src_idle_pct = 38;
	int snk_idle_pct = 62;
	int hold_cycles = 0;
	int mismatches = 0;
	logic [8:0] file_bytes[$];
	res_t pending_results[$];

	phase_t p_phase = PH_HEADER;
	logic [4:0] p_hdr_idx = '0;
	logic [7:0] p_type = '0;
	logic [7:0] p_depth = '0;
	logic [7:0] p_map_type = '0;
	logic [7:0] p_map_depth = '0;
	logic [15:0] p_width = '0;
	logic [15:0] p_height = '0;
	logic [15:0] p_map_len = '0;
	logic [23:0] p_skip = '0;
	logic [31:0] p_gather = '0;
	logic [31:0] p_pixels_left = '0;
	logic [1:0] p_byte_idx = '0;
	logic [7:0] p_pkt_left = '0;
	logic p_pkt_run = 1'b0;

	// Error rows carry their expected code; the other rows are checked against the predictor.
	tga_file_t dir_tab [17] = '{
		'{TYPE_RAW, DEPTH_24, 16'd2, 16'd2, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 0, 0, ERR_NONE},
		'{TYPE_RLE, DEPTH_32, 16'd16, 16'd9, 8'd0, 8'd0, 16'd0, 8'd0, 128, 128, 100, 0, 0,
			ERR_NONE},
		'{TYPE_RLE, DEPTH_24, 16'd3, 16'd3, 8'd0, 8'd0, 16'd0, 8'd0, 1, 4, 0, 3, 0, ERR_NONE},
		'{TYPE_RAW, DEPTH_32, 16'd1, 16'd1, 8'd255, 8'd0, 16'd0, 8'd0, 1, 1, 0, 0, 0, ERR_NONE},
		'{TYPE_RLE, DEPTH_24, 16'd2, 16'd2, 8'd2, 8'd1, 16'd3, 8'd15, 1, 3, 50, 0, 0, ERR_NONE},
		'{TYPE_RLE, DEPTH_32, 16'd2, 16'd1, 8'd0, 8'd0, 16'd5, 8'd24, 1, 2, 50, 1, 0, ERR_NONE},
		'{8'd0, DEPTH_24, 16'd1, 16'd1, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 4, 0, ERR_TYPE},
		'{8'd255, DEPTH_32, 16'd0, 16'd1, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 1, 0, ERR_TYPE},
		'{TYPE_RAW, 8'd16, 16'd2, 16'd2, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 2, 0, ERR_SIZE},
		'{TYPE_RLE, DEPTH_24, 16'd0, 16'd3, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 0, 0, ERR_SIZE},
		'{TYPE_RLE, DEPTH_32, 16'd3, 16'd0, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 0, 0, ERR_SIZE},
		'{TYPE_RAW, 8'd255, 16'd1, 16'd1, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 1, 0, ERR_SIZE},
		'{TYPE_RLE, DEPTH_32, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 16'd0, 8'd0, 1, 128, 50, 0, 18,
			ERR_TRUNC},
		'{TYPE_RAW, DEPTH_24, 16'hFFFF, 16'd2, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 0, 26,
			ERR_NONE},
		'{TYPE_RAW, DEPTH_24, 16'd4, 16'd4, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 0, 5, ERR_TRUNC},
		'{8'd3, DEPTH_24, 16'd1, 16'd1, 8'd0, 8'd0, 16'd0, 8'd0, 1, 1, 0, 0, 18, ERR_TYPE},
		'{TYPE_RAW, DEPTH_32, 16'd1, 16'd1, 8'd10, 8'd0, 16'd0, 8'd0, 1, 1, 0, 0, 22, ERR_NONE}
	};

	tga_rle_image_decoder_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit decode_byte(input logic [7:0] b, input logic eof, output res_t r);
		bit got;
		bit done;
		int nbytes;
		logic [31:0] pix;
		logic [31:0] count;
		got = 1'b0;
		done = 1'b0;
		r = '0;
		case (p_phase)
			PH_HEADER: begin
				case (p_hdr_idx)
					HDR_ID_LEN: p_skip = {16'd0, b};
					HDR_MAP_TYPE: p_map_type = b;
					HDR_IMG_TYPE: p_type = b;
					HDR_MAP_LEN_LO: p_map_len[7:0] = b;
					HDR_MAP_LEN_HI: p_map_len[15:8] = b;
					HDR_MAP_DEPTH: p_map_depth = b;
					HDR_WIDTH_LO: p_width[7:0] = b;
					HDR_WIDTH_HI: p_width[15:8] = b;
					HDR_HEIGHT_LO: p_height[7:0] = b;
					HDR_HEIGHT_HI: p_height[15:8] = b;
					HDR_DEPTH: p_depth = b;
					default: ;
				endcase
				if (p_hdr_idx != HDR_LAST) begin
					p_hdr_idx++;
				end else begin
					p_hdr_idx = '0;
					got = 1'b1;
					if (p_type != TYPE_RAW && p_type != TYPE_RLE) begin
						p_phase = PH_ERROR;
						done = 1'b1;
						r.kind = KIND_ERROR;
						r.error_code = ERR_TYPE;
					end else if (p_width == 0 || p_height == 0 ||
							(p_depth != DEPTH_24 && p_depth != DEPTH_32)) begin
						p_phase = PH_ERROR;
						done = 1'b1;
						r.kind = KIND_ERROR;
						r.error_code = ERR_SIZE;
					end else begin
						if (p_map_type != 0)
							p_skip = p_skip + 24'(32'(p_map_len) *
								((32'(p_map_depth) + 32'd7) >> 3));
						p_pixels_left = 32'(p_width) * 32'(p_height);
						p_gather = '0;
						p_byte_idx = '0;
						p_pkt_left = '0;
						p_pkt_run = 1'b0;
						if (p_skip != 0)
							p_phase = PH_SKIP;
						else
							p_phase = (p_type == TYPE_RAW) ? PH_RAWIMG : PH_PKTHEAD;
						r.kind = KIND_HEADER;
						r.image_width = p_width;
						r.image_height = p_height;
						r.has_alpha = (p_depth == DEPTH_32);
					end
				end
			end
			PH_SKIP: begin
				p_skip = p_skip - 24'd1;
				if (p_skip == 0)
					p_phase = (p_type == TYPE_RAW) ? PH_RAWIMG : PH_PKTHEAD;
			end
			PH_RAWIMG, PH_PKTPIX: begin
				nbytes = (p_depth == DEPTH_32) ? 4 : 3;
				p_gather = p_gather | (32'(b) << (8 * p_byte_idx));
				if (int'(p_byte_idx) + 1 < nbytes) begin
					p_byte_idx++;
				end else begin
					pix = p_gather | ((nbytes == 3) ? 32'hFF00_0000 : 32'd0);
					p_gather = '0;
					p_byte_idx = '0;
					count = 32'd1;
					if (p_phase == PH_PKTPIX) begin
						if (p_pkt_run) begin
							count = 32'(p_pkt_left);
							if (count > p_pixels_left)
								count = p_pixels_left;
							p_pkt_left = '0;
						end else begin
							p_pkt_left = p_pkt_left - 8'd1;
						end
						if (p_pkt_left == 0)
							p_phase = PH_PKTHEAD;
					end
					p_pixels_left = p_pixels_left - count;
					if (p_pixels_left == 0) begin
						p_phase = PH_DONE;
						done = 1'b1;
					end
					got = 1'b1;
					r.kind = KIND_RUN;
					r.red = pix[23:16];
					r.green = pix[15:8];
					r.blue = pix[7:0];
					r.alpha = pix[31:24];
					r.run_length = count[7:0];
					r.last_run = (p_pixels_left == 0);
					r.has_alpha = (nbytes == 4);
				end
			end
			PH_PKTHEAD: begin
				p_pkt_run = b[7];
				p_pkt_left = {1'b0, b[6:0]} + 8'd1;
				p_phase = PH_PKTPIX;
			end
			default: done = 1'b1;
		endcase
		if (eof) begin
			if (!done) begin
				r = '0;
				r.kind = KIND_ERROR;
				r.error_code = ERR_TRUNC;
				got = 1'b1;
			end
			p_phase = PH_HEADER;
			p_hdr_idx = '0;
		end
		return got;
	endfunction

	task automatic build_file(input tga_file_t c);
		logic [7:0] hdr [18];
		longint pixels;
		int nbytes;
		int n;
		int skip_n;
		bit run;
		file_bytes.delete();
		foreach (hdr[i])
			hdr[i] = 8'($urandom);
		hdr[HDR_ID_LEN] = c.id_len;
		hdr[HDR_MAP_TYPE] = c.map_type;
		hdr[HDR_IMG_TYPE] = c.img_type;
		hdr[HDR_MAP_LEN_LO] = c.map_len[7:0];
		hdr[HDR_MAP_LEN_HI] = c.map_len[15:8];
		hdr[HDR_MAP_DEPTH] = c.map_depth;
		hdr[HDR_WIDTH_LO] = c.width[7:0];
		hdr[HDR_WIDTH_HI] = c.width[15:8];
		hdr[HDR_HEIGHT_LO] = c.height[7:0];
		hdr[HDR_HEIGHT_HI] = c.height[15:8];
		hdr[HDR_DEPTH] = c.depth;
		foreach (hdr[i])
			file_bytes.push_back({1'b0, hdr[i]});
		if ((c.img_type == TYPE_RAW || c.img_type == TYPE_RLE) && c.width != 0 &&
				c.height != 0 && (c.depth == DEPTH_24 || c.depth == DEPTH_32)) begin
			skip_n = int'(c.id_len) +
				((c.map_type != 0) ? int'(c.map_len) * ((int'(c.map_depth) + 7) / 8) : 0);
			repeat (skip_n)
				file_bytes.push_back({1'b0, 8'($urandom)});
			pixels = longint'(c.width) * longint'(c.height);
			nbytes = (c.depth == DEPTH_32) ? 4 : 3;
			while (pixels > 0 && !(c.cut > 0 && file_bytes.size() >= c.cut)) begin
				if (c.img_type == TYPE_RAW) begin
					repeat (nbytes)
						file_bytes.push_back({1'b0, 8'($urandom)});
					pixels--;
				end else begin
					n = $urandom_range(c.max_pkt, c.min_pkt);
					run = ($urandom_range(99, 0) < c.run_pct);
					if (!run && n > pixels)
						n = int'(pixels) + $urandom_range(1, 0);
					file_bytes.push_back({1'b0, run, 7'(n - 1)});
					repeat (run ? nbytes : n * nbytes)
						file_bytes.push_back({1'b0, 8'($urandom)});
					pixels -= n;
				end
			end
		end
		repeat (c.tail)
			file_bytes.push_back({1'b0, 8'($urandom)});
		if (c.cut > 0)
			while (file_bytes.size() > c.cut)
				void'(file_bytes.pop_back());
		file_bytes[file_bytes.size() - 1][8] = 1'b1;
	endtask

	task automatic send_file(input logic [1:0] pin);
		foreach (file_bytes[i]) begin
			while ($urandom_range(99, 0) < src_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= file_bytes[i][7:0];
			s_tlast <= file_bytes[i][8];
			item_pin <= pin;
			do @(posedge clk); while (!s_tready);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		res_t r;
		if (arst_n && s_tvalid && s_tready) begin
			if (decode_byte(s_tdata, s_tlast, r)) begin
				if (item_pin != ERR_NONE) begin
					r = '0;
					r.kind = KIND_ERROR;
					r.error_code = item_pin;
				end
				pending_results.push_back(r);
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item with no expectation: tuser %0d tdata %h", m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", 16'(want.kind), 16'(m_tuser));
				check_field("error_code", 16'(want.error_code), 16'(m_tdata[1:0]));
				check_field("red", 16'(want.red), 16'(m_tdata[9:2]));
				check_field("green", 16'(want.green), 16'(m_tdata[17:10]));
				check_field("blue", 16'(want.blue), 16'(m_tdata[25:18]));
				check_field("alpha", 16'(want.alpha), 16'(m_tdata[33:26]));
				check_field("run_length", 16'(want.run_length), 16'(m_tdata[41:34]));
				check_field("last_run", 16'(want.last_run), 16'(m_tlast));
				check_field("image_width", want.image_width, m_tdata[57:42]);
				check_field("image_height", want.image_height, m_tdata[73:58]);
				check_field("has_alpha", 16'(want.has_alpha), 16'(m_tdata[74]));
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
				@(posedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tga_rle_image_decoder_top test failed");
		$finish;
	end

	initial begin
		tga_file_t f;
		int sent;
		int pick;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_tab[i]) begin
			build_file(dir_tab[i]);
			send_file(dir_tab[i].pin);
		end

		// The output side stalls for a long stretch while files keep arriving.
		hold_cycles = HOLD_OFF_CYCLES;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= 2 * RANDOM_ITEMS / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else if (sent >= RANDOM_ITEMS / 3) begin
				src_idle_pct = 62;
				snk_idle_pct = 38;
			end
			pick = $urandom_range(99, 0);
			if (pick < 12) begin
				file_bytes.delete();
				repeat ($urandom_range(40, 1))
					file_bytes.push_back({($urandom_range(19, 0) == 0), 8'($urandom)});
				file_bytes[file_bytes.size() - 1][8] = 1'b1;
			end else begin
				f.img_type = ($urandom_range(2, 0) == 0) ? TYPE_RAW : TYPE_RLE;
				f.depth = $urandom_range(1, 0) ? DEPTH_32 : DEPTH_24;
				f.width = 16'(($urandom_range(9, 0) == 0) ? $urandom_range(12, 1) :
					$urandom_range(4, 1));
				f.height = 16'(($urandom_range(9, 0) == 0) ? $urandom_range(12, 1) :
					$urandom_range(4, 1));
				f.id_len = 8'(($urandom_range(4, 0) == 0) ? $urandom_range(6, 1) : 0);
				f.map_type = 8'(($urandom_range(6, 0) == 0) ? $urandom_range(255, 1) : 0);
				f.map_len = 16'($urandom_range(3, 0));
				f.map_depth = 8'($urandom_range(40, 0));
				f.min_pkt = 1;
				f.max_pkt = $urandom_range(1, 0) ? 4 : 128;
				f.run_pct = $urandom_range(100, 0);
				f.tail = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
				f.cut = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 1) : 0;
				f.pin = ERR_NONE;
				if (pick < 25) begin
					case ($urandom_range(3, 0))
						0: f.img_type = 8'($urandom);
						1: f.depth = 8'($urandom);
						2: f.width = '0;
						default: f.height = '0;
					endcase
				end
				build_file(f);
			end
			sent += file_bytes.size();
			send_file(ERR_NONE);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tga_rle_image_decoder_top test passed");
		else
			$display("tga_rle_image_decoder_top test failed");
		$finish;
	end

endmodule
